@@ rtl/core/tvti_pkg.sv @@
// Package for the text value type inference block.
// Holds the phase and type codes, the record passed from front to back,
// the range limits and the saturating counter helper. No dependencies.
package tvti_pkg;

    localparam logic [15:0] MAX_LEN     = 16'd65535;
    localparam logic [15:0] INT_MAX_CH  = 16'd19;
    localparam logic [15:0] MAG_MAX_DIG = 16'd20;

    localparam int QUEUE_DEPTH = 2;
    localparam int QW          = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [63:0] NEG_TINY_LIM   = 64'd128;
    localparam logic [63:0] NEG_SMALL_LIM  = 64'd32768;
    localparam logic [63:0] NEG_MEDIUM_LIM = 64'd8388608;
    localparam logic [63:0] U_TINY_LIM     = 64'd255;
    localparam logic [63:0] U_SMALL_LIM    = 64'd65535;
    localparam logic [63:0] U_MEDIUM_LIM   = 64'd16777215;
    localparam logic [63:0] U_INT_LIM      = 64'd2147483647;

    localparam logic signed [16:0] MINUS_ONE = -17'sd1;

    typedef enum logic [2:0] {
        PH_START = 3'd0,
        PH_MINUS = 3'd1,
        PH_INT   = 3'd2,
        PH_DOT   = 3'd3,
        PH_FRAC  = 3'd4,
        PH_OTHER = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        T_NULL    = 3'd0,
        T_TINY    = 3'd1,
        T_SMALL   = 3'd2,
        T_MEDIUM  = 3'd3,
        T_INT     = 3'd4,
        T_BIG     = 3'd5,
        T_DECIMAL = 3'd6,
        T_VARCHAR = 3'd7
    } t_type;

    // Everything the back end needs to classify one finished value.
    typedef struct packed {
        t_phase      phase;
        logic        negative;
        logic [63:0] magnitude;
        logic [15:0] char_count;
        logic [15:0] digit_count;
        logic [15:0] frac_digits;
    } t_rec;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v < MAX_LEN) ? v + 16'd1 : MAX_LEN;
    endfunction

endpackage

@@ rtl/core/tvti_front.sv @@
// Front end: takes one character per beat, tracks the pattern phase, counts
// and magnitude, and pushes a finished value record on the last beat.
// Depends on tvti_pkg.
module tvti_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_character,
    input  logic          i_no_char,
    input  logic          i_last,
    input  logic          i_q_full,
    output logic          o_push,
    output tvti_pkg::t_rec o_rec
);
    import tvti_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_neg, n_neg;
    logic [63:0] r_mag, n_mag;
    logic [15:0] r_chars, n_chars;
    logic [15:0] r_digs, n_digs;
    logic [15:0] r_frac, n_frac;

    logic accept;
    logic is_digit;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign is_digit = (i_character >= CH_ZERO) && (i_character <= CH_NINE);

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_chars = r_chars;
        n_digs  = r_digs;
        n_frac  = r_frac;
        if (!i_no_char) begin
            n_chars = sat_inc(r_chars);
            if (is_digit) begin
                n_digs = sat_inc(r_digs);
            end
            case (r_phase)
                PH_START: begin
                    if (i_character == CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_MINUS;
                    end else if (is_digit) begin
                        n_phase = PH_INT;
                    end else if (i_character == CH_DOT) begin
                        n_phase = PH_DOT;
                    end else begin
                        n_phase = PH_OTHER;
                    end
                end
                PH_MINUS, PH_INT: begin
                    if (is_digit) begin
                        n_phase = PH_INT;
                    end else if (i_character == CH_DOT) begin
                        n_phase = PH_DOT;
                    end else begin
                        n_phase = PH_OTHER;
                    end
                end
                PH_DOT, PH_FRAC: begin
                    if (is_digit) begin
                        n_phase = PH_FRAC;
                        n_frac  = sat_inc(r_frac);
                    end else begin
                        n_phase = PH_OTHER;
                    end
                end
                default: begin
                    n_phase = PH_OTHER;
                end
            endcase
            // Times ten as two shifts and an add; the digit value is the low nibble.
            if (n_phase == PH_INT && is_digit && n_digs <= MAG_MAX_DIG) begin
                n_mag = (r_mag << 3) + (r_mag << 1) + {60'd0, i_character[3:0]};
            end
        end
    end

    always_comb begin
        o_push            = accept && i_last;
        o_rec.phase       = n_phase;
        o_rec.negative    = n_neg;
        o_rec.magnitude   = n_mag;
        o_rec.char_count  = n_chars;
        o_rec.digit_count = n_digs;
        o_rec.frac_digits = n_frac;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_phase <= PH_START;
            r_neg   <= 1'b0;
            r_mag   <= 64'd0;
            r_chars <= 16'd0;
            r_digs  <= 16'd0;
            r_frac  <= 16'd0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_chars <= n_chars;
            r_digs  <= n_digs;
            r_frac  <= n_frac;
        end
    end

endmodule

@@ rtl/core/tvti_queue.sv @@
// Short queue of finished value records between the front and back ends.
// Depends on tvti_pkg for the record type and depth.
module tvti_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tvti_pkg::t_rec i_rec,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output tvti_pkg::t_rec o_rec
);
    import tvti_pkg::*;

    t_rec        r_mem [QUEUE_DEPTH];
    logic [QW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QW:0]   r_count;

    assign o_full  = (r_count == (QW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/core/tvti_back.sv @@
// Back end: classifies a finished value record into a column type and holds
// the result in an output register until it is taken. Depends on tvti_pkg.
module tvti_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  tvti_pkg::t_rec        i_rec,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [2:0]            o_type_code,
    output logic signed [16:0]    o_precision,
    output logic signed [16:0]    o_scale,
    output logic                  o_is_unsigned
);
    import tvti_pkg::*;

    logic               r_valid;
    t_type              r_type, n_type;
    logic signed [16:0] r_prec, n_prec;
    logic signed [16:0] r_scale, n_scale;
    logic               r_uns, n_uns;

    logic signed [16:0] len17, digs17;

    assign o_pop = i_q_valid && (!r_valid || i_ready);
    assign len17  = {1'b0, i_rec.char_count};
    assign digs17 = {1'b0, i_rec.digit_count};

    always_comb begin
        n_type  = T_VARCHAR;
        n_prec  = len17;
        n_scale = MINUS_ONE;
        n_uns   = 1'b0;
        case (i_rec.phase)
            PH_START: begin
                n_type = T_NULL;
                n_prec = MINUS_ONE;
            end
            PH_INT: begin
                if (i_rec.char_count > INT_MAX_CH) begin
                    n_type = T_VARCHAR;
                end else if (i_rec.negative && i_rec.magnitude != 64'd0) begin
                    n_prec = digs17;
                    if (i_rec.magnitude <= NEG_TINY_LIM) begin
                        n_type = T_TINY;
                    end else if (i_rec.magnitude <= NEG_SMALL_LIM) begin
                        n_type = T_SMALL;
                    end else if (i_rec.magnitude <= NEG_MEDIUM_LIM) begin
                        n_type = T_MEDIUM;
                    end else begin
                        n_type = T_INT;
                    end
                end else begin
                    // Minus zero falls here and reads as unsigned.
                    n_prec = digs17;
                    n_uns  = 1'b1;
                    if (i_rec.magnitude <= U_TINY_LIM) begin
                        n_type = T_TINY;
                    end else if (i_rec.magnitude <= U_SMALL_LIM) begin
                        n_type = T_SMALL;
                    end else if (i_rec.magnitude <= U_MEDIUM_LIM) begin
                        n_type = T_MEDIUM;
                    end else if (i_rec.magnitude <= U_INT_LIM) begin
                        n_type = T_INT;
                    end else begin
                        n_type = T_BIG;
                    end
                end
            end
            PH_FRAC: begin
                n_type  = T_DECIMAL;
                n_prec  = digs17;
                n_scale = {1'b0, i_rec.frac_digits};
            end
            default: begin
                n_type = T_VARCHAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_type  <= n_type;
            r_prec  <= n_prec;
            r_scale <= n_scale;
            r_uns   <= n_uns;
        end
    end

    assign o_valid       = r_valid;
    assign o_type_code   = r_type;
    assign o_precision   = r_prec;
    assign o_scale       = r_scale;
    assign o_is_unsigned = r_uns;

endmodule

@@ rtl/core/text_value_type_inference_top.sv @@
// Text value type inference. Each input beat carries one byte of a field
// value; the beat marked last closes the value and yields one result beat with
// the narrowest column type, precision, scale and signedness. The block takes
// one character every cycle while input ready is high; the front end tracks
// the pattern and the 64-bit magnitude (times ten plus digit per beat), and a
// two-entry queue hands finished values to the back end, which classifies
// them and registers the result. The queue registers a finished value when
// its last beat is accepted; the back end then takes it from the queue head
// into its result register once that register is free or taken. Input keeps
// flowing while the output is stalled until the result register and both
// queue entries hold finished values; only then does the input ready drop.
module text_value_type_inference_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_character,
    input  logic               i_no_char,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [2:0]         o_type_code,
    output logic signed [16:0] o_precision,
    output logic signed [16:0] o_scale,
    output logic               o_is_unsigned
);
    import tvti_pkg::*;

    t_rec push_rec, pop_rec;
    logic push, pop, q_full, q_valid;

    tvti_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_character (i_character),
        .i_no_char   (i_no_char),
        .i_last      (i_last),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_rec       (push_rec)
    );

    tvti_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_rec   (pop_rec)
    );

    tvti_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_rec         (pop_rec),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_type_code   (o_type_code),
        .o_precision   (o_precision),
        .o_scale       (o_scale),
        .o_is_unsigned (o_is_unsigned)
    );

endmodule

@@ rtl/core/tvti_checker.sv @@
// Port-level checks for the text value type inference block, bound to the
// top level. Depends on tvti_pkg for the type codes.
module tvti_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input logic [2:0]         o_type_code,
    input logic signed [16:0] o_precision,
    input logic signed [16:0] o_scale,
    input logic               o_is_unsigned
);
    import tvti_pkg::*;

    // No result beat may show up right after reset.
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_type_code)
            && $stable(o_precision) && $stable(o_scale) && $stable(o_is_unsigned))
        else $error("stalled result beat changed");

    a_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_type_code == T_NULL |->
            o_precision == MINUS_ONE && o_scale == MINUS_ONE && !o_is_unsigned)
        else $error("null result with bad fields");

    a_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_type_code != T_DECIMAL |-> o_scale == MINUS_ONE)
        else $error("scale set on a non-decimal result");

    a_unsigned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_unsigned |->
            o_type_code == T_TINY || o_type_code == T_SMALL || o_type_code == T_MEDIUM
            || o_type_code == T_INT || o_type_code == T_BIG)
        else $error("unsigned flag on a non-integer result");

endmodule

bind text_value_type_inference_top tvti_checker u_tvti_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_type_code   (o_type_code),
    .o_precision   (o_precision),
    .o_scale       (o_scale),
    .o_is_unsigned (o_is_unsigned)
);
